### design/itmm_pkg.sv
// shared types, constants and tables for the inch token scanner
package itmm_pkg;

  localparam int unsigned CharW             = 8;
  localparam int unsigned ScaleW            = 16;
  localparam int unsigned OutW              = 46;
  localparam int unsigned MaxDigitsDefault  = 9;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [ScaleW-1:0] ScaleReset = 16'd2540;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharNl    = 8'h0A;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharOne   = 8'h31;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharI     = 8'h69;
  localparam logic [CharW-1:0] CharN     = 8'h6E;

  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_I,
    PH_N,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_e;

  // powers of ten from 10^0 to 10^18, zero for larger exponents
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    case (n)
      0:       p = 64'd1;
      1:       p = 64'd10;
      2:       p = 64'd100;
      3:       p = 64'd1000;
      4:       p = 64'd10000;
      5:       p = 64'd100000;
      6:       p = 64'd1000000;
      7:       p = 64'd10000000;
      8:       p = 64'd100000000;
      9:       p = 64'd1000000000;
      10:      p = 64'd10000000000;
      11:      p = 64'd100000000000;
      12:      p = 64'd1000000000000;
      13:      p = 64'd10000000000000;
      14:      p = 64'd100000000000000;
      15:      p = 64'd1000000000000000;
      16:      p = 64'd10000000000000000;
      17:      p = 64'd100000000000000000;
      18:      p = 64'd1000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

  // bits needed for a mantissa of d decimal digits
  function automatic int unsigned mant_width(input int unsigned d);
    return $clog2(pow10(d));
  endfunction

  // bits needed for a digit count from 0 to d
  function automatic int unsigned cnt_width(input int unsigned d);
    return $clog2(d + 1);
  endfunction

endpackage

### design/itmm_char_if.sv
// character input channel
interface itmm_char_if import itmm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

### design/itmm_mm_if.sv
// converted length output channel
interface itmm_mm_if import itmm_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] converted_value;

  modport source (output valid, output converted_value, input ready);
  modport sink   (input valid, input converted_value, output ready);
endinterface

### design/itmm_front.sv
// scanner front end: classifies bytes and collects the digits of a word
module itmm_front import itmm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  itmm_char_if.sink                           in_if,
  input  logic                                full_i,
  output logic                                push_o,
  output logic [mant_width(MAX_DIGITS)-1:0]   mant_o,
  output logic [cnt_width(MAX_DIGITS)-1:0]    frac_o
);

  localparam int unsigned MantW = mant_width(MAX_DIGITS);
  localparam int unsigned CntW  = cnt_width(MAX_DIGITS);

  phase_e           phase_q, phase_d;
  logic [MantW-1:0] mant_q, mant_d;
  logic [CntW-1:0]  frac_q, frac_d;
  logic [CntW-1:0]  dcnt_q, dcnt_d;

  logic [CharW-1:0] c;
  logic             accept, is_sep, is_dig, rej;
  logic [MantW-1:0] mant_x10;

  assign c      = in_if.char_in;
  assign is_sep = (c == CharSpace) || (c == CharNl);
  assign is_dig = (c >= CharZero) && (c <= CharNine);
  assign accept = in_if.valid && in_if.ready;

  // only a finished word needs room in the queue
  assign in_if.ready = !((phase_q == PH_N) && full_i);

  assign mant_x10 = MantW'({mant_q, 3'b000} + {mant_q, 1'b0}) + MantW'(c[3:0]);

  always_comb begin
    phase_d = phase_q;
    mant_d  = mant_q;
    frac_d  = frac_q;
    dcnt_d  = dcnt_q;
    push_o  = 1'b0;
    rej     = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_START: begin
          if (c inside {[CharOne:CharNine]}) begin
            mant_d  = MantW'(c[3:0]);
            dcnt_d  = CntW'(1);
            phase_d = PH_INT;
          end else begin
            rej = 1'b1;
          end
        end
        PH_INT, PH_FRAC: begin
          if (is_dig) begin
            if (dcnt_q >= CntW'(MAX_DIGITS)) begin
              rej = 1'b1;
            end else begin
              mant_d = mant_x10;
              dcnt_d = dcnt_q + CntW'(1);
              if (phase_q == PH_FRAC) begin
                frac_d = frac_q + CntW'(1);
              end
            end
          end else if (c == CharI) begin
            phase_d = PH_I;
          end else if ((c == CharDot) && (phase_q == PH_INT)) begin
            phase_d = PH_FRAC;
          end else begin
            rej = 1'b1;
          end
        end
        PH_I: begin
          if (c == CharN) begin
            phase_d = PH_N;
          end else begin
            rej = 1'b1;
          end
        end
        PH_N: begin
          if (is_sep) begin
            push_o  = 1'b1;
            phase_d = PH_START;
            mant_d  = '0;
            frac_d  = '0;
            dcnt_d  = '0;
          end else begin
            rej = 1'b1;
          end
        end
        PH_SKIP: begin
          phase_d = is_sep ? PH_START : PH_SKIP;
        end
        default: begin
          rej = 1'b1;
        end
      endcase
      // a separator starts a new word at once, anything else skips the word
      if (rej) begin
        phase_d = is_sep ? PH_START : PH_SKIP;
        mant_d  = '0;
        frac_d  = '0;
        dcnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      mant_q  <= '0;
      frac_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      mant_q  <= mant_d;
      frac_q  <= frac_d;
      dcnt_q  <= dcnt_d;
    end
  end

  assign mant_o = mant_q;
  assign frac_o = frac_q;

  a_dcnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count above limit");

  a_frac_below_dcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frac_q < dcnt_q) || (frac_q == '0))
    else $error("fraction count not below digit count");

  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("word pushed into full queue");

endmodule

### design/itmm_queue.sv
// short word queue between scanner and converter
module itmm_queue import itmm_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

### design/itmm_back.sv
// converter back end: serial multiply by scale, serial divide by power of ten
module itmm_back import itmm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ScaleW-1:0]                   cfg_data_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  input  logic [mant_width(MAX_DIGITS)-1:0]   mant_i,
  input  logic [cnt_width(MAX_DIGITS)-1:0]    frac_i,
  itmm_mm_if.source                           out_if
);

  localparam int unsigned MantW = mant_width(MAX_DIGITS);
  localparam int unsigned CntW  = cnt_width(MAX_DIGITS);
  localparam int unsigned ProdW = MantW + ScaleW;
  localparam int unsigned DivW  = ProdW + 1;
  localparam int unsigned StepW = $clog2(DivW);

  bk_state_e         state_q, state_d;
  logic [ScaleW-1:0] scale_q;
  logic [ProdW-1:0]  acc_q, mcand_q;
  logic [ScaleW-1:0] mplier_q;
  logic [CntW-1:0]   frac_q;
  logic [StepW-1:0]  step_q;
  logic [DivW-1:0]   divd_q;
  logic [MantW-1:0]  divisor_q;
  logic [MantW:0]    rem_q;
  logic              sat_q;
  logic [OutW-1:0]   res_q;

  logic [ProdW-1:0]  acc_sum;
  logic              acc_ovf64, acc_hi;
  logic [MantW:0]    rem_sh, rem_nx;
  logic              ge;
  logic [DivW-1:0]   divd_nx;
  logic              quo_hi;
  logic              last_step;

  // shift-add product, one scale bit per cycle
  assign acc_sum = mplier_q[0] ? acc_q + mcand_q : acc_q;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q[MantW-1:0], divd_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, divisor_q};
  assign rem_nx  = ge ? rem_sh - {1'b0, divisor_q} : rem_sh;
  assign divd_nx = {divd_q[DivW-2:0], ge};

  assign last_step = (step_q == '0);

  always_comb begin
    acc_ovf64 = 1'b0;
    acc_hi    = 1'b0;
    quo_hi    = 1'b0;
    for (int unsigned i = 64; i < ProdW; i++) begin
      acc_ovf64 = acc_ovf64 | acc_sum[i];
    end
    for (int unsigned i = OutW; i < ProdW; i++) begin
      acc_hi = acc_hi | acc_sum[i];
    end
    for (int unsigned i = OutW; i < DivW; i++) begin
      quo_hi = quo_hi | divd_nx[i];
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        if (last_step) begin
          state_d = (frac_q == '0) ? BK_OUT : BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_if.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      scale_q <= ScaleReset;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        acc_q    <= '0;
        mcand_q  <= ProdW'(mant_i);
        mplier_q <= scale_q;
        frac_q   <= frac_i;
        step_q   <= StepW'(ScaleW - 1);
      end
      BK_MUL: begin
        acc_q    <= acc_sum;
        mcand_q  <= {mcand_q[ProdW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[ScaleW-1:1]};
        step_q   <= step_q - StepW'(1);
        if (last_step) begin
          sat_q     <= acc_ovf64;
          res_q     <= acc_hi ? '1 : OutW'(acc_sum);
          // adding half the divisor turns the floor division into round half up
          divd_q    <= DivW'(acc_sum) + DivW'(pow10(32'(frac_q)) >> 1);
          divisor_q <= MantW'(pow10(32'(frac_q)));
          rem_q     <= '0;
          step_q    <= StepW'(DivW - 1);
        end
      end
      BK_DIV: begin
        rem_q  <= rem_nx;
        divd_q <= divd_nx;
        step_q <= step_q - StepW'(1);
        if (last_step) begin
          res_q <= (sat_q || quo_hi) ? '1 : OutW'(divd_nx);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid           = (state_q == BK_OUT);
  assign out_if.converted_value = res_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < {1'b0, divisor_q}))
    else $error("division remainder not below divisor");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == BK_MUL))
    else $error("pop did not start a conversion");

  a_out_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready) |=> (state_q == BK_IDLE))
    else $error("converter did not return to idle after handoff");

endmodule

### design/inch_token_to_mm_scanner_core.sv
// a word is converted after its closing separator: the shift-add multiplier always runs,
//   the bit-serial divider only when the word has fraction digits
// throughput: one byte per cycle, but not while a finished word waits for a full queue;
//   the converter takes one word at a time and a short queue holds the words behind it
// reset: scanner at start of word, queue empty, scale register 2540
module inch_token_to_mm_scanner_core import itmm_pkg::*; #(
  parameter int unsigned MAX_DIGITS  = MaxDigitsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ScaleW-1:0] cfg_data_i,
  itmm_char_if.sink         in_if,
  itmm_mm_if.source         out_if
);

  localparam int unsigned MantW = mant_width(MAX_DIGITS);
  localparam int unsigned CntW  = cnt_width(MAX_DIGITS);
  localparam int unsigned WordW = MantW + CntW;

  logic             push, pop, full, empty;
  logic [MantW-1:0] f_mant, b_mant;
  logic [CntW-1:0]  f_frac, b_frac;

  itmm_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .mant_o (f_mant),
    .frac_o (f_frac)
  );

  itmm_queue #(
    .WIDTH (WordW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_mant, f_frac}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  ({b_mant, b_frac}),
    .empty_o (empty)
  );

  itmm_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .empty_i    (empty),
    .pop_o      (pop),
    .mant_i     (b_mant),
    .frac_i     (b_frac),
    .out_if     (out_if)
  );

endmodule

### bench/inch_token_to_mm_scanner_core_tb.sv
// self-checking testbench for the inch token scanner core
import itmm_pkg::*;

class inch_word_tracker #(int unsigned MAX_DIG = MaxDigitsDefault);
  localparam int unsigned MantW = mant_width(MAX_DIG);
  localparam int unsigned CntW  = cnt_width(MAX_DIG);

  logic [ScaleW-1:0] scale;
  phase_e            scan_ph;
  logic [MantW-1:0]  mantissa;
  logic [CntW-1:0]   frac_cnt;
  logic [CntW-1:0]   digit_cnt;
  logic [OutW-1:0]   expected_mm[$];
  int unsigned       failures;

  function new();
    scale     = ScaleReset;
    failures  = 0;
    clear_word(PH_START);
  endfunction

  function void set_scale(input logic [ScaleW-1:0] value);
    scale = value;
  endfunction

  function int unsigned pending();
    return expected_mm.size();
  endfunction

  function void clear_word(input phase_e next_ph);
    scan_ph   = next_ph;
    mantissa  = '0;
    frac_cnt  = '0;
    digit_cnt = '0;
  endfunction

  // a separator restarts at once, anything else skips the rest of the word
  function void drop_word(input bit sep);
    clear_word(sep ? PH_START : PH_SKIP);
  endfunction

  function void add_digit(input logic [CharW-1:0] c);
    mantissa  = mantissa * 10 + MantW'(c - CharZero);
    digit_cnt = digit_cnt + 1'b1;
  endfunction

  // mantissa * scale / 10^frac, rounded half up
  function logic [OutW-1:0] scaled_length();
    logic [63:0] prod;
    logic [63:0] div;
    logic [63:0] quot;
    int unsigned k;
    prod = 64'(mantissa) * 64'(scale);
    div  = 64'd1;
    for (k = 0; k < frac_cnt; k++) div = div * 10;
    quot = prod / div;
    if (prod % div >= div - div / 2) quot = quot + 1;
    return OutW'(quot);
  endfunction

  function void note_char(input logic [CharW-1:0] c);
    bit sep;
    bit dig;
    sep = (c == CharSpace) || (c == CharNl);
    dig = (c >= CharZero) && (c <= CharNine);
    case (scan_ph)
      PH_START: begin
        if (c >= CharOne && c <= CharNine) begin
          add_digit(c);
          scan_ph = PH_INT;
        end else begin
          drop_word(sep);
        end
      end
      PH_INT, PH_FRAC: begin
        if (dig) begin
          if (digit_cnt >= MAX_DIG) begin
            drop_word(1'b0);
          end else begin
            add_digit(c);
            if (scan_ph == PH_FRAC) frac_cnt = frac_cnt + 1'b1;
          end
        end else if (c == CharI) begin
          scan_ph = PH_I;
        end else if (c == CharDot && scan_ph == PH_INT) begin
          scan_ph = PH_FRAC;
        end else begin
          drop_word(sep);
        end
      end
      PH_I: begin
        if (c == CharN) scan_ph = PH_N;
        else drop_word(sep);
      end
      PH_N: begin
        if (sep) begin
          expected_mm.push_back(scaled_length());
          clear_word(PH_START);
        end else begin
          drop_word(1'b0);
        end
      end
      default: drop_word(sep);
    endcase
  endfunction

  function void report(input string what, input logic [OutW-1:0] want,
                       input logic [OutW-1:0] got);
    if (failures < 10)
      $display("%0t: %s: expected %0d got %0d", $realtime, what, want, got);
    failures++;
  endfunction

  function void check_length(input logic [OutW-1:0] got);
    logic [OutW-1:0] want;
    if (expected_mm.size() == 0) begin
      report("length with no word pending", '0, got);
    end else begin
      want = expected_mm.pop_front();
      if (got !== want) report("converted_value mismatch", want, got);
    end
  endfunction
endclass

module inch_token_to_mm_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDigits    = MaxDigitsDefault;
  // settle time for the converter to finish a word and any queued words
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned StallLimit   = 3000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ScaleW-1:0] cfg_data_i;

  itmm_char_if char_ch ();
  itmm_mm_if   mm_ch ();

  inch_word_tracker #(MaxDigits) tracker;

  int unsigned bytes_sent;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned quiet_cycles;

  inch_token_to_mm_scanner_core #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (char_ch),
    .out_if    (mm_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stall pattern, switching among four random styles
  initial begin
    int unsigned style;
    int unsigned style_left;
    int unsigned hold;
    int unsigned tick;
    logic        rdy;
    mm_ch.ready = 1'b0;
    style_left  = 0;
    hold        = 0;
    tick        = 0;
    forever begin
      @(negedge clk_i);
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(64, 400);
      end
      style_left--;
      tick++;
      case (style)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = (tick % 5 == 0);
        default: begin
          if (hold > 0) begin
            hold--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 24);
          end
        end
      endcase
      mm_ch.ready <= rdy;
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_ch.valid && char_ch.ready) tracker.note_char(char_ch.char_in);
      if (mm_ch.valid && mm_ch.ready) tracker.check_length(mm_ch.converted_value);
      if ((char_ch.valid && char_ch.ready) || (mm_ch.valid && mm_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL inch_token_to_mm_scanner_core");
        $finish;
      end
    end
  end

  task automatic hold_off(input int unsigned n);
    @(negedge clk_i);
    char_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [CharW-1:0] c);
    if (burst_left == 0) begin
      if (gaps_on && $urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk_i);
    char_ch.valid   <= 1'b1;
    char_ch.char_in <= c;
    do @(posedge clk_i); while (!char_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int unsigned k;
    for (k = 0; k < s.len(); k++) send_byte(CharW'(s[k]));
  endtask

  // stop sending until every converted length has come out
  task automatic drain();
    @(negedge clk_i);
    char_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [ScaleW-1:0] value);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_scale(value);
  endtask

  task automatic send_random_word();
    int unsigned      kind;
    int unsigned      n_int;
    int unsigned      n_frac;
    int unsigned      pos;
    logic [CharW-1:0] w[$];
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      // mostly well-formed words; a few run past the digit limit
      n_int = (kind < 5) ? $urandom_range(MaxDigits - 1, MaxDigits)
                         : $urandom_range(1, MaxDigits);
      w.push_back(CharW'(CharOne + $urandom_range(0, 8)));
      repeat (n_int - 1) w.push_back(CharW'(CharZero + $urandom_range(0, 9)));
      if (kind < 5 || $urandom_range(0, 1)) begin
        w.push_back(CharDot);
        n_frac = (kind < 5) ? $urandom_range(1, 3) : $urandom_range(0, MaxDigits - n_int);
        repeat (n_frac) w.push_back(CharW'(CharZero + $urandom_range(0, 9)));
      end
      w.push_back(CharI);
      w.push_back(CharN);
      w.push_back($urandom_range(0, 1) ? CharSpace : CharNl);
      if (kind >= 65) begin
        pos    = $urandom_range(0, w.size() - 1);
        w[pos] = CharW'($urandom_range(0, 255));
      end
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 6)) w.push_back(CharW'($urandom_range(0, 255)));
      w.push_back(CharSpace);
    end else begin
      repeat ($urandom_range(1, 3)) w.push_back($urandom_range(0, 1) ? CharSpace : CharNl);
    end
    foreach (w[k]) send_byte(w[k]);
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned first;
    bit          drained;
    first   = bytes_sent;
    drained = 1'b0;
    while (bytes_sent - first < n_bytes) begin
      send_random_word();
      if (!drained && bytes_sent - first >= n_bytes / 2) begin
        drain();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    int unsigned      ph;
    logic [ScaleW-1:0] next_scale;
    tracker         = new();
    bytes_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    char_ch.valid   = 1'b0;
    char_ch.char_in = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // separator at word start, point without fraction, mismatch with skip,
    // separator inside a word, non-ascii bytes, too many digits
    send_text("\n9.in ");
    send_text("1a5in 3 ");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text(" 1234567890in\n");
    run_random(250);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       next_scale = 16'd1;
        1:       next_scale = 16'hFFFF;
        4:       next_scale = ScaleReset;
        default: next_scale = ScaleW'($urandom_range(1, 65535));
      endcase
      gaps_on = (ph % 2 == 0);
      write_scale(next_scale);
      send_text("999999999in 1.5in ");
      run_random(180);
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("PASS inch_token_to_mm_scanner_core");
    else
      $display("FAIL inch_token_to_mm_scanner_core");
    $finish;
  end
endmodule
